// ----- rtl/kfsit_pkg.sv -----
// shared types, field widths and codes for the keyframe seek index table
`default_nettype none

package kfsit_pkg;

    // field widths fixed by the stream format
    localparam int KEY_W    = 31;
    localparam int DTS_W    = 64;
    localparam int OFFS_W   = 10;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 10;
    localparam int TOTAL_W  = 11;

    // packed beat widths, padded to whole bytes
    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 184;

    localparam int DEF_CAPACITY = 1024;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEFORE     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OFFS_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

    // one table row
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [DTS_W-1:0] first_dts;
        logic [DTS_W-1:0] last_dts;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/kfsit_store.sv -----
// entry memory: one write port, one read port with registered read data
`default_nettype none

module kfsit_store #(
    parameter int DEPTH = kfsit_pkg::DEF_CAPACITY,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire kfsit_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]   rd_addr,
    output kfsit_pkg::entry_t    rd_data
);
    import kfsit_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data valid in the cycle after the address
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/keyframe_seek_index_table_core.sv -----
// top level: request sequencer, binary search and result register of the keyframe index table
`default_nettype none

// Keyframe seek index table. Each s_ beat is one request: append an entry (kept only when its
// key rises above the last stored key), a floor lookup (last entry with key not above the
// target, returning the first timestamp of the entry back_offset places earlier), or a clear.
// Every request gives exactly one m_ beat. The table sits in a single-port-read memory, and all
// work goes through that read port under a small sequencer, one read per cycle: a lookup reads
// the first key, then one key per halving step, then the floor entry and the offset entry.
// s_tready is high only while the sequencer is idle; a finished result waits in the output
// register without holding up the next request.
module keyframe_seek_index_table_core #(
    parameter int CAPACITY = kfsit_pkg::DEF_CAPACITY
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: key_index[30:0], in_first_dts[94:31], in_last_dts[158:95], back_offset[168:159]
    input  wire logic [kfsit_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  wire logic [kfsit_pkg::REQ_W-1:0]     s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: status[2:0], appended[3], found_position[13:4], found_key[44:14],
    // found_first_dts[108:45], found_last_dts[172:109], entry_total[183:173]
    output logic [kfsit_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);
    import kfsit_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (AW > OFFS_W) ? AW : OFFS_W;
    localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_APP   = 7'b0000010,
        S_CHK0  = 7'b0000100,
        S_SRCH  = 7'b0001000,
        S_FLOOR = 7'b0010000,
        S_OFFS  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic [KEY_W-1:0]      key_reg, key_next;
    logic [DTS_W-1:0]      in_first_reg, in_first_next;
    logic [DTS_W-1:0]      in_last_reg, in_last_next;
    logic [OFFS_W-1:0]     offs_reg, offs_next;
    logic [AW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [AW-1:0]         mid_reg, mid_next;
    logic [AW-1:0]         p_reg, p_next;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                  res_app_reg, res_app_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic [KEY_W-1:0]      res_key_reg, res_key_next;
    logic [DTS_W-1:0]      res_first_reg, res_first_next;
    logic [DTS_W-1:0]      res_last_reg, res_last_next;

    // memory port signals
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    entry_t                wr_data;
    logic [AW-1:0]         rd_addr;
    entry_t                rd_data;

    // search step signals
    logic [AW-1:0]         step_lo;
    logic [CW-1:0]         step_hi;
    logic [CW-1:0]         step_diff;
    logic [CW-1:0]         step_half;
    logic [AW-1:0]         step_mid;
    logic                  step_more;
    logic                  step_short;
    logic [CW-1:0]         cnt_m1;
    logic [XW-1:0]         p_ext;
    logic [XW-1:0]         back_pos;
    logic [TW-1:0]         total_ext;
    logic                  rising;
    logic                  table_full;

    kfsit_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign cnt_m1     = count_reg - CW'(1);
    assign table_full = (count_reg == CW'(CAPACITY));
    assign rising     = (count_reg == '0) || (rd_data.key < key_reg);
    assign p_ext      = XW'(p_reg);
    assign back_pos   = p_ext - XW'(offs_reg);
    assign total_ext  = TW'(count_reg);

    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = '{key: key_reg, first_dts: in_first_reg, last_dts: in_last_reg};

    // bounds for the next halving step: fresh range after the first-key check,
    // otherwise narrowed by the key just read at mid
    always_comb begin
        if (state_reg == S_SRCH) begin
            if (rd_data.key <= key_reg) begin
                step_lo = mid_reg;
                step_hi = hi_reg;
            end else begin
                step_lo = lo_reg;
                step_hi = CW'(mid_reg);
            end
        end else begin
            step_lo = '0;
            step_hi = count_reg;
        end
    end

    // shared step unit: range width, midpoint and offset check on the floor candidate
    assign step_diff  = step_hi - CW'(step_lo);
    assign step_half  = step_diff >> 1;
    assign step_mid   = step_lo + step_half[AW-1:0];
    assign step_more  = (step_diff > CW'(1));
    assign step_short = (XW'(step_lo) < XW'(offs_reg));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        key_next        = key_reg;
        in_first_next   = in_first_reg;
        in_last_next    = in_last_reg;
        offs_next       = offs_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        p_next          = p_reg;
        res_status_next = res_status_reg;
        res_app_next    = res_app_reg;
        res_pos_next    = res_pos_reg;
        res_key_next    = res_key_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;
        wr_en           = 1'b0;
        rd_addr         = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next        = s_tdata[30:0];
                    in_first_next   = s_tdata[94:31];
                    in_last_next    = s_tdata[158:95];
                    offs_next       = s_tdata[168:159];
                    res_status_next = ST_OK;
                    res_app_next    = 1'b0;
                    res_pos_next    = '0;
                    res_key_next    = '0;
                    res_first_next  = '0;
                    res_last_next   = '0;
                    case (s_tuser)
                        REQ_APPEND: begin
                            // fetch the last stored key for the order check
                            rd_addr    = cnt_m1[AW-1:0];
                            state_next = S_APP;
                        end
                        REQ_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end else begin
                                rd_addr    = '0;
                                state_next = S_CHK0;
                            end
                        end
                        REQ_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_APP: begin
                if (rising) begin
                    if (table_full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        count_next   = count_reg + CW'(1);
                        res_app_next = 1'b1;
                    end
                end
                state_next = S_DONE;
            end

            S_CHK0, S_SRCH: begin
                if ((state_reg == S_CHK0) && (key_reg < rd_data.key)) begin
                    res_status_next = ST_BEFORE;
                    state_next      = S_DONE;
                end else if (step_more) begin
                    lo_next    = step_lo;
                    hi_next    = step_hi;
                    mid_next   = step_mid;
                    rd_addr    = step_mid;
                    state_next = S_SRCH;
                end else if (step_short) begin
                    res_status_next = ST_OFFS_RANGE;
                    state_next      = S_DONE;
                end else begin
                    p_next     = step_lo;
                    rd_addr    = step_lo;
                    state_next = S_FLOOR;
                end
            end

            S_FLOOR: begin
                // floor entry in hand, now fetch the entry back_offset places earlier
                res_pos_next  = p_ext[POS_W-1:0];
                res_key_next  = rd_data.key;
                res_last_next = rd_data.last_dts;
                rd_addr       = back_pos[AW-1:0];
                state_next    = S_OFFS;
            end

            S_OFFS: begin
                res_first_next = rd_data.first_dts;
                state_next     = S_DONE;
            end

            S_DONE: begin
                // hand the result to the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {total_ext[TOTAL_W-1:0], res_last_reg, res_first_reg,
                                    res_key_reg, res_pos_reg, res_app_reg, res_status_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_data_reg     <= m_data_next;
        key_reg        <= key_next;
        in_first_reg   <= in_first_next;
        in_last_reg    <= in_last_next;
        offs_reg       <= offs_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_app_reg    <= res_app_next;
        res_pos_reg    <= res_pos_next;
        res_key_reg    <= res_key_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
    end

endmodule

`default_nettype wire
